>>> rtl/smh_pkg.sv
package smh_pkg;

   // Field widths
   localparam int CMD_W   = 2;
   localparam int IDX_W   = 6;
   localparam int DUTY_W  = 7;
   localparam int COUNT_W = 16;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int SCALE_W = 6;

   // Command codes (code 3 behaves as a tick)
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LEFT  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RIGHT = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_LIMIT    = 2'd1;

   localparam logic [CSR_W-1:0] STEP_INTERVAL_RST = 16'd500;
   localparam logic [CSR_W-1:0] TURN_LIMIT_RST    = 16'd256;

   // Microstep sequence
   localparam logic [IDX_W-1:0] IDX_ZERO = 6'd0;
   localparam logic [IDX_W-1:0] IDX_END  = 6'd32;
   localparam logic [3:0]       QUARTER  = 4'd8;

   // Duty constants in percent
   localparam logic [DUTY_W-1:0] DUTY_MID  = 7'd50;
   localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

   // Quarter-wave sine table and gain
   localparam int unsigned GAIN    = 10;
   localparam int unsigned PERCENT = 100;
   localparam int unsigned SINE_TAB [0:8] = '{0, 98, 191, 278, 354, 416, 462, 490, 500};

   // Gain folded into the table at elaboration, so the lookup needs no divider
   localparam logic [SCALE_W-1:0] SCALED_TAB [0:8] = '{
      SCALE_W'(SINE_TAB[0] * GAIN / PERCENT),
      SCALE_W'(SINE_TAB[1] * GAIN / PERCENT),
      SCALE_W'(SINE_TAB[2] * GAIN / PERCENT),
      SCALE_W'(SINE_TAB[3] * GAIN / PERCENT),
      SCALE_W'(SINE_TAB[4] * GAIN / PERCENT),
      SCALE_W'(SINE_TAB[5] * GAIN / PERCENT),
      SCALE_W'(SINE_TAB[6] * GAIN / PERCENT),
      SCALE_W'(SINE_TAB[7] * GAIN / PERCENT),
      SCALE_W'(SINE_TAB[8] * GAIN / PERCENT)
   };

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_LEFT  = 2'd1,
      MODE_RIGHT = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      POS_UNKNOWN = 2'd0,
      POS_LEFT    = 2'd1,
      POS_RIGHT   = 2'd2
   } pos_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             left_stop_n;
      logic             right_stop_n;
   } item_type;

   typedef struct packed {
      logic [CSR_W-1:0] step_interval;
      logic [CSR_W-1:0] turn_limit;
   } cfg_type;

   typedef struct packed {
      logic [DUTY_W-1:0] a1;
      logic [DUTY_W-1:0] a2;
      logic [DUTY_W-1:0] b1;
      logic [DUTY_W-1:0] b2;
   } duty_set_type;

   typedef struct packed {
      duty_set_type       duty;
      logic               bridge_enable;
      mode_type           motion;
      pos_type            position;
      logic [COUNT_W-1:0] turns_done;
      logic               move_finished;
   } result_type;

   // Scaled sine (or cosine) of a quarter-wave step, gain applied
   function automatic logic [SCALE_W-1:0] scaled(input logic [3:0] k, input logic cosine);
      logic [3:0] i;
      begin
         i = (k > QUARTER) ? QUARTER : k;
         if (cosine) begin
            i = QUARTER - i;
         end
         scaled = SCALED_TAB[i];
      end
   endfunction

endpackage

>>> rtl/smh_duty.sv
module smh_duty
   import smh_pkg::*;
(
   input  logic [IDX_W-1:0] idx_i,
   output duty_set_type     duty_o
);

   logic [IDX_W-1:0]  offs;
   logic [3:0]        k;
   logic [DUTY_W-1:0] s;
   logic [DUTY_W-1:0] c;
   logic [DUTY_W-1:0] d1;
   logic [DUTY_W-1:0] d3;

   // Quadrant select and phase duties
   always_comb begin
      case (idx_i) inside
         [6'd0:6'd8]: begin
            offs = idx_i;
         end
         [6'd9:6'd16]: begin
            offs = idx_i - 6'd8;
         end
         [6'd17:6'd24]: begin
            offs = idx_i - 6'd16;
         end
         default: begin
            offs = idx_i - 6'd24;
         end
      endcase
      k = offs[3:0];
      s = DUTY_W'(scaled(k, 1'b0));
      c = DUTY_W'(scaled(k, 1'b1));
      case (idx_i) inside
         [6'd0:6'd8]: begin
            d1 = DUTY_MID - c;
            d3 = DUTY_MID - s;
         end
         [6'd9:6'd16]: begin
            d1 = DUTY_MID + s;
            d3 = DUTY_MID - c;
         end
         [6'd17:6'd24]: begin
            d1 = DUTY_MID + c;
            d3 = DUTY_MID + s;
         end
         default: begin
            d1 = DUTY_MID - s;
            d3 = DUTY_MID + c;
         end
      endcase
      duty_o.a1 = d1;
      duty_o.a2 = DUTY_FULL - d1;
      duty_o.b1 = d3;
      duty_o.b2 = DUTY_FULL - d3;
   end

endmodule

>>> rtl/smh_ctrl.sv
module smh_ctrl
   import smh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  item_type   item_i,
   input  cfg_type    cfg_i,
   output result_type result_o
);

   mode_type           mode_ff, mode_in;
   pos_type            pos_ff, pos_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [COUNT_W-1:0] turns_ff, turns_in;
   logic [COUNT_W-1:0] wait_ff, wait_in;
   duty_set_type       duty_ff, duty_in;

   logic               finished;
   logic               apply;
   logic [IDX_W-1:0]   apply_idx;
   duty_set_type       duty_calc;
   logic               left;
   logic               stop_sw;
   pos_type            side;
   logic [IDX_W-1:0]   start_idx;
   logic               at_end;
   logic [COUNT_W-1:0] t1;
   logic [COUNT_W-1:0] t2;
   logic [IDX_W-1:0]   idx1;
   logic [COUNT_W-1:0] wait_reload;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] t);
      begin
         sat_inc = (t == {COUNT_W{1'b1}}) ? t : t + 1'b1;
      end
   endfunction

   smh_duty u_duty (
      .idx_i  (apply_idx),
      .duty_o (duty_calc)
   );

   // Next state for one item
   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      turns_in  = turns_ff;
      wait_in   = wait_ff;
      finished  = 1'b0;
      apply     = 1'b0;
      apply_idx = idx_ff;

      left        = (mode_ff == MODE_IDLE) ? (item_i.command == CMD_LEFT)
                                           : (mode_ff == MODE_LEFT);
      stop_sw     = left ? !item_i.left_stop_n : !item_i.right_stop_n;
      side        = left ? POS_LEFT : POS_RIGHT;
      start_idx   = left ? IDX_ZERO : IDX_END;
      wait_reload = (cfg_i.step_interval == '0) ? '0 : cfg_i.step_interval - 1'b1;

      // turn bookkeeping at a microstep slot
      at_end = (idx_ff == (left ? IDX_END : IDX_ZERO));
      t1     = at_end ? sat_inc(turns_ff) : turns_ff;
      t2     = sat_inc(t1);
      idx1   = at_end ? start_idx : idx_ff;

      if (step_en) begin
         case (mode_ff)
            MODE_IDLE: begin
               if (item_i.command == CMD_LEFT || item_i.command == CMD_RIGHT) begin
                  if (pos_ff == side) begin
                     finished = 1'b1;
                  end else begin
                     turns_in = '0;
                     wait_in  = '0;
                     idx_in   = start_idx;
                     if (stop_sw || cfg_i.turn_limit == '0) begin
                        // ends at once with no turn
                        finished = 1'b1;
                        pos_in   = (cfg_i.turn_limit == '0) ? POS_UNKNOWN : side;
                     end else begin
                        mode_in   = left ? MODE_LEFT : MODE_RIGHT;
                        apply     = 1'b1;
                        apply_idx = start_idx;
                        idx_in    = left ? start_idx + 1'b1 : start_idx - 1'b1;
                        wait_in   = wait_reload;
                     end
                  end
               end
            end
            MODE_LEFT, MODE_RIGHT: begin
               if (wait_ff != '0) begin
                  wait_in = wait_ff - 1'b1;
               end else if (at_end && t1 >= cfg_i.turn_limit) begin
                  // turn limit reached: give up
                  turns_in = t1;
                  pos_in   = POS_UNKNOWN;
                  mode_in  = MODE_IDLE;
                  wait_in  = '0;
                  finished = 1'b1;
               end else if (stop_sw) begin
                  // switch hit: partial turn counts
                  turns_in = t2;
                  idx_in   = idx1;
                  pos_in   = (t2 >= cfg_i.turn_limit) ? POS_UNKNOWN : side;
                  mode_in  = MODE_IDLE;
                  wait_in  = '0;
                  finished = 1'b1;
               end else begin
                  turns_in  = t1;
                  apply     = 1'b1;
                  apply_idx = idx1;
                  idx_in    = left ? idx1 + 1'b1 : idx1 - 1'b1;
                  wait_in   = wait_reload;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end

      duty_in = apply ? duty_calc : duty_ff;

      result_o.duty          = duty_in;
      result_o.bridge_enable = (mode_in != MODE_IDLE);
      result_o.motion        = mode_in;
      result_o.position      = pos_in;
      result_o.turns_done    = turns_in;
      result_o.move_finished = finished;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= POS_UNKNOWN;
         idx_ff   <= '0;
         turns_ff <= '0;
         wait_ff  <= '0;
         duty_ff  <= '{a1: DUTY_MID, a2: DUTY_MID, b1: DUTY_MID, b2: DUTY_MID};
      end else begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         idx_ff   <= idx_in;
         turns_ff <= turns_in;
         wait_ff  <= wait_in;
         duty_ff  <= duty_in;
      end
   end

   // No wait pending while idle
   a_idle_no_wait: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_IDLE |-> wait_ff == '0)
      else $error("wait count left over while idle");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_END)
      else $error("microstep index out of range");

   // Complementary duties always sum to full scale
   a_duty_pair: assert property (@(posedge clock) disable iff (reset)
      (duty_ff.a1 + duty_ff.a2 == DUTY_FULL) && (duty_ff.b1 + duty_ff.b2 == DUTY_FULL))
      else $error("bridge duties not complementary");

   // A move starts with a cleared turn count
   a_start_turns: assert property (@(posedge clock) disable iff (reset)
      (step_en && mode_ff == MODE_IDLE && mode_in != MODE_IDLE) |=> turns_ff == '0)
      else $error("turn count not cleared at move start");

endmodule

>>> rtl/stepper_microstep_homing.sv
// Results are registered: request register, step logic, then the response register.
// Throughput: one item per cycle unless rsp_stall holds a waiting result; each item is one
// pass through the step logic between the request register and the response register.
// req_stall: rsp_stall while a result waits and an item sits in the request register.
// Reset (synchronous, active high): idle, position unknown, duties 50 percent,
// step_interval 500, turn_limit 256.
module stepper_microstep_homing
   import smh_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CMD_W-1:0]     req_command,
   input  logic                 req_left_stop_n,
   input  logic                 req_right_stop_n,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [DUTY_W-1:0]    rsp_duty_a1,
   output logic [DUTY_W-1:0]    rsp_duty_a2,
   output logic [DUTY_W-1:0]    rsp_duty_b1,
   output logic [DUTY_W-1:0]    rsp_duty_b2,
   output logic                 rsp_bridge_enable,
   output logic [1:0]           rsp_motion,
   output logic [1:0]           rsp_position,
   output logic [COUNT_W-1:0]   rsp_turns_done,
   output logic                 rsp_move_finished,
   // register write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic       req_valid_ff;
   item_type   item_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type result_in;
   cfg_type    cfg_ff;
   logic       advance;
   logic       step_en;

   // Pipeline advances when the response register is free or being emptied
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step_en   = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;
   assign csr_ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_interval <= STEP_INTERVAL_RST;
         cfg_ff.turn_limit    <= TURN_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STEP_INTERVAL: cfg_ff.step_interval <= csr_wdata;
            CSR_TURN_LIMIT:    cfg_ff.turn_limit    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.command      <= req_command;
         item_ff.left_stop_n  <= req_left_stop_n;
         item_ff.right_stop_n <= req_right_stop_n;
      end
   end

   smh_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .item_i   (item_ff),
      .cfg_i    (cfg_ff),
      .result_o (result_in)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_duty_a1       = rsp_ff.duty.a1;
   assign rsp_duty_a2       = rsp_ff.duty.a2;
   assign rsp_duty_b1       = rsp_ff.duty.b1;
   assign rsp_duty_b2       = rsp_ff.duty.b2;
   assign rsp_bridge_enable = rsp_ff.bridge_enable;
   assign rsp_motion        = rsp_ff.motion;
   assign rsp_position      = rsp_ff.position;
   assign rsp_turns_done    = rsp_ff.turns_done;
   assign rsp_move_finished = rsp_ff.move_finished;

endmodule

>>> tb/homing_check_pkg.sv
`timescale 1ns / 100ps

package homing_check_pkg;
   import smh_pkg::*;

   // Codes the block treats specially: command 3 acts as a tick, index 3 is unmapped
   localparam logic [CMD_W-1:0]     CMD_SPARE = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam int Q_STEPS    = QUARTER;
   localparam int MID_DUTY   = DUTY_MID;
   localparam int FULL_DUTY  = DUTY_FULL;
   localparam int REPORT_MAX = 10;

   class homing_scoreboard;
      // register copies
      logic [CSR_W-1:0]   step_interval;
      logic [CSR_W-1:0]   turn_limit;
      // motor state
      mode_type           mode;
      pos_type            pos;
      logic [IDX_W-1:0]   microstep;
      logic [COUNT_W-1:0] turns;
      logic [CSR_W-1:0]   wait_ticks;
      duty_set_type       duty;
      logic               finished;

      result_type  expected_outputs[$];
      int unsigned mismatches;
      int unsigned results_checked;
      int unsigned moves_ended;

      function new();
         step_interval   = STEP_INTERVAL_RST;
         turn_limit      = TURN_LIMIT_RST;
         mode            = MODE_IDLE;
         pos             = POS_UNKNOWN;
         microstep       = IDX_ZERO;
         turns           = '0;
         wait_ticks      = '0;
         duty            = '{DUTY_MID, DUTY_MID, DUTY_MID, DUTY_MID};
         finished        = 1'b0;
         mismatches      = 0;
         results_checked = 0;
         moves_ended     = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [CSR_W-1:0] value);
         if (index == CSR_STEP_INTERVAL) begin
            step_interval = value;
         end else if (index == CSR_TURN_LIMIT) begin
            turn_limit = value;
         end
      endfunction

      // sine in percent after the 10/100 gain, quarter wave
      function int quarter_wave(int k, bit cosine);
         int i;
         i = (k > Q_STEPS) ? Q_STEPS : k;
         if (cosine) begin
            i = Q_STEPS - i;
         end
         case (i)
            0: return 0;
            1: return 9;
            2: return 19;
            3: return 27;
            4: return 35;
            5: return 41;
            6: return 46;
            7: return 49;
            default: return 50;
         endcase
      endfunction

      function void bump_turns();
         if (turns != '1) begin
            turns++;
         end
      endfunction

      function void finish_move(bit to_left);
         pos        = (turns >= turn_limit) ? POS_UNKNOWN : (to_left ? POS_LEFT : POS_RIGHT);
         mode       = MODE_IDLE;
         wait_ticks = '0;
         finished   = 1'b1;
         moves_ended++;
      endfunction

      // one microstep slot: turn bookkeeping, switch check, then new duties
      function void microstep_slot(bit to_left, logic lsn, logic rsn);
         int s, d1, d3;
         if (microstep == (to_left ? IDX_END : IDX_ZERO)) begin
            bump_turns();
            if (turns >= turn_limit) begin
               finish_move(to_left);
               return;
            end
            microstep = to_left ? IDX_ZERO : IDX_END;
         end
         if ((to_left ? lsn : rsn) == 1'b0) begin
            bump_turns();
            finish_move(to_left);
            return;
         end
         s = microstep;
         if (s <= Q_STEPS) begin
            d1 = MID_DUTY - quarter_wave(s, 1'b1);
            d3 = MID_DUTY - quarter_wave(s, 1'b0);
         end else if (s <= 2 * Q_STEPS) begin
            d1 = MID_DUTY + quarter_wave(s - Q_STEPS, 1'b0);
            d3 = MID_DUTY - quarter_wave(s - Q_STEPS, 1'b1);
         end else if (s <= 3 * Q_STEPS) begin
            d1 = MID_DUTY + quarter_wave(s - 2 * Q_STEPS, 1'b1);
            d3 = MID_DUTY + quarter_wave(s - 2 * Q_STEPS, 1'b0);
         end else begin
            d1 = MID_DUTY - quarter_wave(s - 3 * Q_STEPS, 1'b0);
            d3 = MID_DUTY + quarter_wave(s - 3 * Q_STEPS, 1'b1);
         end
         duty.a1    = DUTY_W'(d1);
         duty.a2    = DUTY_W'(FULL_DUTY - d1);
         duty.b1    = DUTY_W'(d3);
         duty.b2    = DUTY_W'(FULL_DUTY - d3);
         microstep  = to_left ? microstep + 1'b1 : microstep - 1'b1;
         wait_ticks = (step_interval != 0) ? step_interval - 1'b1 : '0;
      endfunction

      // advance the motor by one accepted command and queue the outputs it gives
      function void take_command(item_type it);
         bit         to_left;
         result_type want;
         finished = 1'b0;
         if (mode == MODE_IDLE) begin
            if (it.command == CMD_LEFT || it.command == CMD_RIGHT) begin
               to_left = (it.command == CMD_LEFT);
               if (pos == (to_left ? POS_LEFT : POS_RIGHT)) begin
                  // already parked on that side
                  finished = 1'b1;
                  moves_ended++;
               end else begin
                  turns      = '0;
                  microstep  = to_left ? IDX_ZERO : IDX_END;
                  wait_ticks = '0;
                  mode       = to_left ? MODE_LEFT : MODE_RIGHT;
                  if ((to_left ? it.left_stop_n : it.right_stop_n) == 1'b0 || turn_limit == 0) begin
                     finish_move(to_left);
                  end else begin
                     microstep_slot(to_left, it.left_stop_n, it.right_stop_n);
                  end
               end
            end
         end else if (wait_ticks != 0) begin
            wait_ticks--;
         end else begin
            microstep_slot(mode == MODE_LEFT, it.left_stop_n, it.right_stop_n);
         end
         want.duty          = duty;
         want.bridge_enable = (mode != MODE_IDLE);
         want.motion        = mode;
         want.position      = pos;
         want.turns_done    = turns;
         want.move_finished = finished;
         expected_outputs.push_back(want);
      endfunction

      function string describe(result_type r);
         return $sformatf("duty %0d/%0d/%0d/%0d bridge %0b motion %0d pos %0d turns %0d done %0b",
                          r.duty.a1, r.duty.a2, r.duty.b1, r.duty.b2, r.bridge_enable,
                          r.motion, r.position, r.turns_done, r.move_finished);
      endfunction

      // compare one transferred result with the oldest expectation
      function void compare_outputs(result_type got);
         result_type want;
         results_checked++;
         if (expected_outputs.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("result %0d arrived with nothing expected: %s",
                        results_checked, describe(got));
            end
            return;
         end
         want = expected_outputs.pop_front();
         if (got.duty.a1 !== want.duty.a1 || got.duty.a2 !== want.duty.a2 ||
             got.duty.b1 !== want.duty.b1 || got.duty.b2 !== want.duty.b2 ||
             got.bridge_enable !== want.bridge_enable || got.motion !== want.motion ||
             got.position !== want.position || got.turns_done !== want.turns_done ||
             got.move_finished !== want.move_finished) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("mismatch on result %0d", results_checked);
               $display("  expected %s", describe(want));
               $display("  actual   %s", describe(got));
            end
         end
      endfunction
   endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import smh_pkg::*;
   import homing_check_pkg::*;

   localparam int RESET_CYCLES   = 12;
   localparam int RESULT_LATENCY = 2;
   localparam int HOLDOFF_CYCLES = 60;
   localparam int QUIET_LIMIT    = 2000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [CMD_W-1:0]     req_command = CMD_TICK;
   logic                 req_left_stop_n = 1'b1;
   logic                 req_right_stop_n = 1'b1;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [DUTY_W-1:0]    rsp_duty_a1;
   logic [DUTY_W-1:0]    rsp_duty_a2;
   logic [DUTY_W-1:0]    rsp_duty_b1;
   logic [DUTY_W-1:0]    rsp_duty_b2;
   logic                 rsp_bridge_enable;
   logic [1:0]           rsp_motion;
   logic [1:0]           rsp_position;
   logic [COUNT_W-1:0]   rsp_turns_done;
   logic                 rsp_move_finished;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_STEP_INTERVAL;
   logic [CSR_W-1:0]     csr_wdata = '0;

   homing_scoreboard sb;
   int unsigned      items_sent = 0;
   int unsigned      settings_used = 0;
   int               idle_pct = 10;
   bit               holdoff_request = 1'b0;

   stepper_microstep_homing dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic item_type make_item(logic [CMD_W-1:0] cmd, logic lsn, logic rsn);
      item_type it;
      it.command      = cmd;
      it.left_stop_n  = lsn;
      it.right_stop_n = rsn;
      return it;
   endfunction

   // one command transfer, with an occasional gap in front of it
   task automatic offer_item(input item_type it);
      int gap;
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
         gap = $urandom_range(1, 14);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_command      <= it.command;
      req_left_stop_n  <= it.left_stop_n;
      req_right_stop_n <= it.right_stop_n;
      do @(posedge clock); while (req_stall);
      sb.take_command(it);
      items_sent++;
   endtask

   // stop offering and let every outstanding result come back
   task automatic await_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_outputs.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(index, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_settings(input logic [CSR_W-1:0] interval, input logic [CSR_W-1:0] limit);
      write_reg(CSR_STEP_INTERVAL, interval);
      write_reg(CSR_TURN_LIMIT, limit);
      settings_used++;
   endtask

   // a spin command followed by ticks until the move ends or the cap is hit;
   // hit_max is the upper bound of the per-tick chance, in percent, of the target switch closing
   task automatic run_move(input int hit_max, input int cap);
      item_type it;
      bit       go_left, to_left;
      int       hit, n;
      go_left = 1'($urandom_range(0, 1));
      hit     = $urandom_range(0, hit_max);
      it      = make_item(go_left ? CMD_LEFT : CMD_RIGHT, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) != 0) begin
         if (go_left) begin
            it.left_stop_n = 1'b1;
         end else begin
            it.right_stop_n = 1'b1;
         end
      end
      offer_item(it);
      n = 1;
      while (sb.mode != MODE_IDLE && n < cap) begin
         to_left = (sb.mode == MODE_LEFT);
         it.command = ($urandom_range(0, 9) == 0) ? CMD_W'($urandom_range(0, 3)) : CMD_TICK;
         it.left_stop_n  = 1'($urandom_range(0, 1));
         it.right_stop_n = 1'($urandom_range(0, 1));
         if (to_left) begin
            it.left_stop_n = ($urandom_range(1, 100) > hit);
         end else begin
            it.right_stop_n = ($urandom_range(1, 100) > hit);
         end
         offer_item(it);
         n++;
      end
   endtask

   // mostly well-formed moves, some stray commands in between
   task automatic run_phase(input int budget, input int hit_max);
      int unsigned first;
      first = items_sent;
      while (items_sent - first < budget) begin
         if ($urandom_range(0, 6) == 0) begin
            offer_item(make_item(CMD_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1))));
         end else begin
            run_move(hit_max, budget - (items_sent - first));
         end
      end
   endtask

   // result side: check every transfer
   initial begin : result_sink
      result_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.duty.a1       = rsp_duty_a1;
            got.duty.a2       = rsp_duty_a2;
            got.duty.b1       = rsp_duty_b1;
            got.duty.b2       = rsp_duty_b2;
            got.bridge_enable = rsp_bridge_enable;
            got.motion        = mode_type'(rsp_motion);
            got.position      = pos_type'(rsp_position);
            got.turns_done    = rsp_turns_done;
            got.move_finished = rsp_move_finished;
            sb.compare_outputs(got);
         end
      end
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin : result_backpressure
      int n;
      forever begin
         @(negedge clock);
         if (holdoff_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
            holdoff_request = 1'b0;
         end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            n = $urandom_range(1, 14);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // give up if no transfer happens for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin : stimulus
      bit go_left;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // unmapped register index must be ignored
      write_reg(CSR_SPARE, 16'hA5A5);

      // reset settings: idle ticks, switch closed at start, already parked
      offer_item(make_item(CMD_TICK, 1'b1, 1'b1));
      offer_item(make_item(CMD_SPARE, 1'b0, 1'b0));
      offer_item(make_item(CMD_LEFT, 1'b0, 1'b1));
      offer_item(make_item(CMD_LEFT, 1'b1, 1'b1));
      offer_item(make_item(CMD_RIGHT, 1'b1, 1'b0));
      offer_item(make_item(CMD_RIGHT, 1'b0, 1'b1));
      await_results();

      // spin commands while moving count as ticks; moves cut short by the switch
      apply_settings(16'd1, 16'd2);
      offer_item(make_item(CMD_LEFT, 1'b1, 1'b1));
      offer_item(make_item(CMD_TICK, 1'b1, 1'b0));
      offer_item(make_item(CMD_RIGHT, 1'b1, 1'b1));
      offer_item(make_item(CMD_SPARE, 1'b1, 1'b1));
      offer_item(make_item(CMD_LEFT, 1'b1, 1'b1));
      offer_item(make_item(CMD_TICK, 1'b0, 1'b1));
      offer_item(make_item(CMD_RIGHT, 1'b1, 1'b1));
      repeat (3) offer_item(make_item(CMD_TICK, 1'b1, 1'b1));
      offer_item(make_item(CMD_TICK, 1'b1, 1'b0));
      await_results();

      // zero interval and zero turn limit
      apply_settings(16'd0, 16'd0);
      offer_item(make_item(CMD_LEFT, 1'b1, 1'b1));
      offer_item(make_item(CMD_RIGHT, 1'b1, 1'b1));
      await_results();

      // random moves under a range of settings
      apply_settings(16'd1, 16'd1);
      run_phase(120, 4);
      await_results();

      idle_pct = 0;
      apply_settings(16'd2, 16'd2);
      run_phase(50, 3);
      holdoff_request = 1'b1;
      run_phase(60, 3);
      await_results();

      idle_pct = 15;
      apply_settings(16'd0, 16'd3);
      run_phase(40, 5);
      await_results();
      run_phase(40, 5);
      await_results();

      idle_pct = 10;
      apply_settings(16'd3, 16'hFFFF);
      run_phase(100, 2);
      await_results();

      apply_settings(16'd1, 16'd0);
      run_phase(30, 5);

      // long interval: close both switches to park, then one full wait
      while (sb.mode != MODE_IDLE) offer_item(make_item(CMD_TICK, 1'b0, 1'b0));
      await_results();
      idle_pct = 0;
      apply_settings(16'd32, 16'hFFFF);
      go_left = (sb.pos != POS_LEFT);
      offer_item(make_item(go_left ? CMD_LEFT : CMD_RIGHT, 1'b1, 1'b1));
      while (sb.mode != MODE_IDLE) offer_item(make_item(CMD_TICK, !go_left, go_left));
      await_results();

      idle_pct = 10;
      apply_settings(16'd5, 16'd1);
      run_phase(80, 3);
      await_results();

      // final stretch without idling
      idle_pct = 0;
      apply_settings(16'd1, 16'd2);
      run_phase(80, 4);
      await_results();

      $display("Run covered %0d commands under %0d register settings, %0d moves ended.",
               items_sent, settings_used, sb.moves_ended);
      $display("Checked %0d results, %0d mismatched, %0d still expected.",
               sb.results_checked, sb.mismatches, sb.expected_outputs.size());
      if (sb.mismatches == 0 && sb.expected_outputs.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> stepper_microstep_homing.f
rtl/smh_pkg.sv
rtl/smh_duty.sv
rtl/smh_ctrl.sv
rtl/stepper_microstep_homing.sv
tb/homing_check_pkg.sv
tb/tb_top.sv
